### design/dbtf_pkg.sv
// Shared types and constants for the directional bright-trail filter.
// No dependencies; every other design file refers to this package by scoped names.
package dbtf_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CH_W      = 16;
  localparam int CFG_W     = 17;
  localparam int CIDX_W    = 2;

  // Rec.601 luma weights in Q0.16, summing to 65536.
  localparam logic [31:0] LUMA_R = 32'd19595;
  localparam logic [31:0] LUMA_G = 32'd38470;
  localparam logic [31:0] LUMA_B = 32'd7471;

  localparam logic [CH_W-1:0] FULL_SCALE = {CH_W{1'b1}};

  localparam logic [CIDX_W-1:0] CFG_DECAY    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_THRESH   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_STRENGTH = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_VERTICAL = 2'd3;

  localparam logic [15:0] DECAY_RST    = 16'd62915;
  localparam logic [15:0] THRESH_RST   = 16'd36045;
  localparam logic [16:0] STRENGTH_RST = 17'd58982;

  typedef logic [CH_W-1:0] chan_t;
  typedef chan_t [2:0] rgb_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take the input word and start the line-store read
    logic look;   // evaluate luma against the threshold
    logic decay;  // decay the previous trail, merge the seed, write back
    logic scale;  // apply strength and load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register is empty or being emptied this cycle
  } status_t;

endpackage

### design/dbtf_ctrl.sv
// Sequencing controller for the directional bright-trail filter.
// Depends on dbtf_pkg for the command and status structures.
module dbtf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dbtf_pkg::status_t status,
  output dbtf_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_DECAY,
    S_SCALE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_LOOK;
      S_LOOK:  state_nxt = S_DECAY;
      S_DECAY: state_nxt = S_SCALE;
      S_SCALE: if (status.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cmd.load  = (state_r == S_IDLE) && in_valid;
  assign cmd.look  = (state_r == S_LOOK);
  assign cmd.decay = (state_r == S_DECAY);
  assign cmd.scale = (state_r == S_SCALE) && status.out_free;

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_LOOK))
    else $error("accepted word did not start the sequence");
  a_look_to_decay: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |=> (state_r == S_DECAY))
    else $error("lookup step not followed by decay step");
  a_decay_to_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECAY) |=> (state_r == S_SCALE))
    else $error("decay step not followed by scale step");
  a_scale_waits: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCALE) && !status.out_free) |=> (state_r == S_SCALE) && !in_ready)
    else $error("scale step left while the output register was blocked");
`endif

endmodule

### design/dbtf_datapath.sv
// Datapath of the directional bright-trail filter: configuration registers,
// column line store, trail arithmetic and output register. Depends on dbtf_pkg.
module dbtf_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dbtf_pkg::cmd_t               cmd,
  output dbtf_pkg::status_t            status,
  input  logic                         cfg_we,
  input  logic [dbtf_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [dbtf_pkg::CFG_W-1:0]   cfg_data,
  input  logic [15:0]                  in_red_in,
  input  logic [15:0]                  in_green_in,
  input  logic [15:0]                  in_blue_in,
  input  logic [15:0]                  in_alpha_in,
  input  logic                         in_line_start,
  input  logic                         in_first_row,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [15:0]                  out_red_out,
  output logic [15:0]                  out_green_out,
  output logic [15:0]                  out_blue_out,
  output logic [15:0]                  out_alpha_out
);

  localparam logic [dbtf_pkg::COL_W-1:0] LAST_COL = dbtf_pkg::COL_W'(dbtf_pkg::MAX_WIDTH - 1);

  // Configuration.
  logic [15:0] decay_r;
  logic [15:0] thresh_r;
  logic [16:0] strength_r;
  logic        vertical_r;

  // Control state.
  logic [dbtf_pkg::COL_W-1:0] col_idx_r;
  logic [dbtf_pkg::COL_W-1:0] col_idx_nxt;
  logic [dbtf_pkg::COL_W-1:0] rd_col;
  dbtf_pkg::rgb_t             row_trail_r;
  logic                       out_valid_r;

  // Payload held for the item in flight.
  dbtf_pkg::rgb_t             src_r;
  logic [15:0]                alpha_r;
  logic                       line_start_r;
  logic                       first_row_r;
  logic [dbtf_pkg::COL_W-1:0] col_r;
  logic                       seed_r;
  dbtf_pkg::rgb_t             trail_r;
  dbtf_pkg::rgb_t             trail_nxt;
  dbtf_pkg::rgb_t             result_nxt;
  logic [47:0]                mem_q_r;
  dbtf_pkg::rgb_t             out_rgb_r;
  logic [15:0]                out_alpha_r;

  logic [47:0] store_mem [dbtf_pkg::MAX_WIDTH];

  logic [31:0] luma;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r    <= dbtf_pkg::DECAY_RST;
      thresh_r   <= dbtf_pkg::THRESH_RST;
      strength_r <= dbtf_pkg::STRENGTH_RST;
      vertical_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dbtf_pkg::CFG_DECAY:    decay_r    <= cfg_data[15:0];
        dbtf_pkg::CFG_THRESH:   thresh_r   <= cfg_data[15:0];
        dbtf_pkg::CFG_STRENGTH: strength_r <= cfg_data;
        dbtf_pkg::CFG_VERTICAL: vertical_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A line start restarts the column count; the count holds at the last entry.
  assign rd_col      = in_line_start ? '0 : col_idx_r;
  assign col_idx_nxt = (rd_col == LAST_COL) ? LAST_COL : rd_col + 1'b1;

  assign luma = dbtf_pkg::LUMA_R * 32'(src_r[0])
              + dbtf_pkg::LUMA_G * 32'(src_r[1])
              + dbtf_pkg::LUMA_B * 32'(src_r[2]);

  always_comb begin
    logic [15:0] prev;
    logic [31:0] dprod;
    logic [15:0] dec;
    logic [32:0] sprod;
    logic [16:0] shifted;
    logic [15:0] scaled;
    for (int c = 0; c < 3; c++) begin
      if (vertical_r) begin
        prev = first_row_r ? 16'd0 : mem_q_r[16*c +: 16];
      end else begin
        prev = line_start_r ? 16'd0 : row_trail_r[c];
      end
      dprod = 32'(prev) * 32'(decay_r);
      dec   = dprod[31:16];
      trail_nxt[c] = (seed_r && (src_r[c] > dec)) ? src_r[c] : dec;

      sprod   = 33'(trail_r[c]) * 33'(strength_r);
      shifted = sprod[32:16];
      scaled  = shifted[16] ? dbtf_pkg::FULL_SCALE : shifted[15:0];
      result_nxt[c] = (src_r[c] > scaled) ? src_r[c] : scaled;
    end
  end

  // Line store: read issued with the accepted word, written back after decay.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem_q_r <= store_mem[rd_col];
    end
    if (cmd.decay && vertical_r) begin
      store_mem[col_r] <= {trail_nxt[2], trail_nxt[1], trail_nxt[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_idx_r   <= '0;
      row_trail_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        col_idx_r <= col_idx_nxt;
      end
      if (cmd.decay && !vertical_r) begin
        row_trail_r <= trail_nxt;
      end
      if (cmd.scale) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_r        <= {in_blue_in, in_green_in, in_red_in};
      alpha_r      <= in_alpha_in;
      line_start_r <= in_line_start;
      first_row_r  <= in_first_row;
      col_r        <= rd_col;
    end
    if (cmd.look) begin
      seed_r <= (luma >= {thresh_r, 16'd0});
    end
    if (cmd.decay) begin
      trail_r <= trail_nxt;
    end
    if (cmd.scale) begin
      out_rgb_r   <= result_nxt;
      out_alpha_r <= alpha_r;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_rgb_r[0];
  assign out_green_out = out_rgb_r[1];
  assign out_blue_out  = out_rgb_r[2];
  assign out_alpha_out = out_alpha_r;

endmodule

### design/directional_bright_trail_filter.sv
// Directional bright-trail filter: a word passes these steps from acceptance to the output
// register (accept with line-store read, luma test, decay and write-back, strength scaling).
// A new word is accepted only once the last one has left that sequence around the single-port
// line store; a full output register that is not taken holds the sequence in its last step.
// Reset restores the register defaults, clears the row trail and column count and empties
// the output register; the column line store is not cleared and needs no clearing pass.
module directional_bright_trail_filter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [15:0]                  in_red_in,
  input  logic [15:0]                  in_green_in,
  input  logic [15:0]                  in_blue_in,
  input  logic [15:0]                  in_alpha_in,
  input  logic                         in_line_start,
  input  logic                         in_first_row,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [15:0]                  out_red_out,
  output logic [15:0]                  out_green_out,
  output logic [15:0]                  out_blue_out,
  output logic [15:0]                  out_alpha_out,
  input  logic                         cfg_we,
  input  logic [dbtf_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [dbtf_pkg::CFG_W-1:0]   cfg_data
);

  dbtf_pkg::cmd_t    cmd;
  dbtf_pkg::status_t status;

  dbtf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dbtf_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .in_alpha_in   (in_alpha_in),
    .in_line_start (in_line_start),
    .in_first_row  (in_first_row),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_alpha_out (out_alpha_out)
  );

endmodule

### tb/sv/dbtf_checker.sv
`timescale 1ns / 1ps
// Checker for the directional bright-trail filter: follows the pixel, output and register
// ports, predicts every output word and compares it with the one the block delivers.
// Depends on dbtf_pkg for widths, register indexes and the luma weights.
module dbtf_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  dbtf_pkg::chan_t             in_red,
  input  dbtf_pkg::chan_t             in_green,
  input  dbtf_pkg::chan_t             in_blue,
  input  dbtf_pkg::chan_t             in_alpha,
  input  logic                        in_line_start,
  input  logic                        in_first_row,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  dbtf_pkg::chan_t             out_red,
  input  dbtf_pkg::chan_t             out_green,
  input  dbtf_pkg::chan_t             out_blue,
  input  dbtf_pkg::chan_t             out_alpha,
  input  logic                        cfg_we,
  input  logic [dbtf_pkg::CIDX_W-1:0] cfg_index,
  input  logic [dbtf_pkg::CFG_W-1:0]  cfg_data,
  output int                          fail_count,
  output int                          outstanding,
  output int                          checked_count
);

  typedef struct packed {
    dbtf_pkg::chan_t red;
    dbtf_pkg::chan_t green;
    dbtf_pkg::chan_t blue;
    dbtf_pkg::chan_t alpha;
  } pixel_t;

  logic [15:0]                decay;
  logic [15:0]                threshold;
  logic [16:0]                strength;
  logic                       vertical;

  // Trails are kept with red at index 0, green at 1 and blue at 2.
  dbtf_pkg::rgb_t             column_trails [dbtf_pkg::MAX_WIDTH];
  dbtf_pkg::rgb_t             row_trail;
  logic [dbtf_pkg::COL_W-1:0] column_pos;
  pixel_t                     expected_pixels [$];
  int                         mismatches = 0;
  int                         checked = 0;

  function automatic dbtf_pkg::chan_t apply_gain(dbtf_pkg::chan_t level, logic [16:0] gain);
    logic [33:0] product;
    product = (34'(level) * 34'(gain)) >> 16;
    return (product > 34'(dbtf_pkg::FULL_SCALE)) ? dbtf_pkg::FULL_SCALE
                                                 : product[dbtf_pkg::CH_W-1:0];
  endfunction

  // Updates the trail state for one accepted pixel and returns the word it should produce.
  function automatic pixel_t advance_trail(dbtf_pkg::rgb_t source, dbtf_pkg::chan_t alpha,
                                           logic line_start, logic first_row);
    logic [33:0]                luma;
    logic                       seeds;
    logic [dbtf_pkg::COL_W-1:0] col;
    dbtf_pkg::rgb_t             prev;
    dbtf_pkg::rgb_t             trail;
    dbtf_pkg::rgb_t             shown;
    dbtf_pkg::chan_t            scaled;
    luma = 34'(source[0]) * 34'(dbtf_pkg::LUMA_R) + 34'(source[1]) * 34'(dbtf_pkg::LUMA_G)
         + 34'(source[2]) * 34'(dbtf_pkg::LUMA_B);
    seeds = (luma >= {2'b00, threshold, 16'h0000});
    col = line_start ? '0 : column_pos;
    for (int c = 0; c < 3; c++) begin
      if (vertical) begin
        prev[c] = first_row ? '0 : column_trails[col][c];
      end else begin
        prev[c] = line_start ? '0 : row_trail[c];
      end
      trail[c] = apply_gain(prev[c], {1'b0, decay});
      if (seeds && source[c] > trail[c]) begin
        trail[c] = source[c];
      end
      scaled = apply_gain(trail[c], strength);
      shown[c] = (source[c] > scaled) ? source[c] : scaled;
    end
    if (vertical) begin
      column_trails[col] = trail;
    end else begin
      row_trail = trail;
    end
    // The column count stops at the last store entry.
    column_pos = (col == dbtf_pkg::COL_W'(dbtf_pkg::MAX_WIDTH - 1)) ? col : col + 1'b1;
    return {shown[0], shown[1], shown[2], alpha};
  endfunction

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    pixel_t predicted;
    if (!rst_n) begin
      decay      = dbtf_pkg::DECAY_RST;
      threshold  = dbtf_pkg::THRESH_RST;
      strength   = dbtf_pkg::STRENGTH_RST;
      vertical   = 1'b1;
      row_trail  = '0;
      column_pos = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dbtf_pkg::CFG_DECAY:    decay     = cfg_data[15:0];
          dbtf_pkg::CFG_THRESH:   threshold = cfg_data[15:0];
          dbtf_pkg::CFG_STRENGTH: strength  = cfg_data;
          dbtf_pkg::CFG_VERTICAL: vertical  = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predicted = advance_trail({in_blue, in_green, in_red}, in_alpha,
                                  in_line_start, in_first_row);
        expected_pixels.insert(expected_pixels.size(), predicted);
      end
      if (out_valid && out_ready) begin
        got = {out_red, out_green, out_blue, out_alpha};
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected output word r=%h g=%h b=%h a=%h at %0t",
                     got.red, got.green, got.blue, got.alpha, $realtime);
          end
        end else begin
          want = expected_pixels.pop_front();
          checked++;
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Output word %0d wrong at %0t: expected r=%h g=%h b=%h a=%h",
                       checked, $realtime, want.red, want.green, want.blue, want.alpha);
              $display("  actual r=%h g=%h b=%h a=%h",
                       got.red, got.green, got.blue, got.alpha);
            end
          end
        end
      end
    end
    fail_count    <= mismatches;
    outstanding   <= expected_pixels.size();
    checked_count <= checked;
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the directional bright-trail filter testbench: clock, reset, pixel and register
// stimulus, output back-pressure and the verdict. Depends on dbtf_pkg, the filter and
// dbtf_checker.
module testbench;

  localparam int RANDOM_PIXELS = 1800;
  localparam int HOLD_CYCLES   = 300;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_phase_t;

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  dbtf_pkg::chan_t             in_red = '0;
  dbtf_pkg::chan_t             in_green = '0;
  dbtf_pkg::chan_t             in_blue = '0;
  dbtf_pkg::chan_t             in_alpha = '0;
  logic                        in_line_start = 1'b0;
  logic                        in_first_row = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  dbtf_pkg::chan_t             out_red;
  dbtf_pkg::chan_t             out_green;
  dbtf_pkg::chan_t             out_blue;
  dbtf_pkg::chan_t             out_alpha;
  logic                        cfg_we = 1'b0;
  logic [dbtf_pkg::CIDX_W-1:0] cfg_index = dbtf_pkg::CFG_DECAY;
  logic [dbtf_pkg::CFG_W-1:0]  cfg_data = '0;

  int fail_count;
  int outstanding;
  int checked_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int pixels_fed = 0;
  int settings_used = 0;

  // Mirror of the column count and of which line-store entries hold a trail.
  logic                       mode_vertical = 1'b1;
  logic [dbtf_pkg::COL_W-1:0] col_mirror = '0;
  bit                         col_written [dbtf_pkg::MAX_WIDTH];

  directional_bright_trail_filter dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_red_in     (in_red),
    .in_green_in   (in_green),
    .in_blue_in    (in_blue),
    .in_alpha_in   (in_alpha),
    .in_line_start (in_line_start),
    .in_first_row  (in_first_row),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red_out   (out_red),
    .out_green_out (out_green),
    .out_blue_out  (out_blue),
    .out_alpha_out (out_alpha),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  dbtf_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_alpha      (in_alpha),
    .in_line_start (in_line_start),
    .in_first_row  (in_first_row),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_idling(input idle_phase_t phase);
    case (phase)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 58; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 58; end
      default:       begin send_idle_pct = 15; recv_stall_pct = 15; end
    endcase
  endtask

  task automatic write_reg(input logic [dbtf_pkg::CIDX_W-1:0] index,
                           input logic [dbtf_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic program_settings(input logic [15:0] decay, input logic [15:0] thr,
                                  input logic [16:0] strength, input logic vertical);
    write_reg(dbtf_pkg::CFG_DECAY, dbtf_pkg::CFG_W'(decay));
    write_reg(dbtf_pkg::CFG_THRESH, dbtf_pkg::CFG_W'(thr));
    write_reg(dbtf_pkg::CFG_STRENGTH, strength);
    write_reg(dbtf_pkg::CFG_VERTICAL, dbtf_pkg::CFG_W'(vertical));
    cfg_we <= 1'b0;
    mode_vertical = vertical;
    settings_used++;
  endtask

  // Lets every word in flight come out before the registers are touched.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic feed_pixel(input dbtf_pkg::chan_t r, input dbtf_pkg::chan_t g,
                            input dbtf_pkg::chan_t b, input dbtf_pkg::chan_t a,
                            input logic ls, input logic fr);
    logic [dbtf_pkg::COL_W-1:0] col;
    col = ls ? '0 : col_mirror;
    // A continuation row may only read a column whose trail was stored since reset.
    if (mode_vertical && !fr && !col_written[col]) begin
      fr = 1'b1;
    end
    if (mode_vertical) begin
      col_written[col] = 1'b1;
    end
    col_mirror = (col == dbtf_pkg::COL_W'(dbtf_pkg::MAX_WIDTH - 1)) ? col : col + 1'b1;
    in_red        <= r;
    in_green      <= g;
    in_blue       <= b;
    in_alpha      <= a;
    in_line_start <= ls;
    in_first_row  <= fr;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pixels_fed++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  function automatic dbtf_pkg::chan_t random_channel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return dbtf_pkg::FULL_SCALE;
      2, 3:    return dbtf_pkg::chan_t'($urandom_range(65535, 45056));
      default: return dbtf_pkg::chan_t'($urandom());
    endcase
  endfunction

  task automatic feed_random_pixel(input logic ls, input logic fr);
    dbtf_pkg::chan_t level;
    if ($urandom_range(3) == 0) begin
      // Bright, nearly grey pixel that is likely to seed.
      level = dbtf_pkg::chan_t'($urandom_range(65535, 40960));
      feed_pixel(level, level ^ dbtf_pkg::chan_t'($urandom_range(4095)),
                 level ^ dbtf_pkg::chan_t'($urandom_range(4095)),
                 dbtf_pkg::chan_t'($urandom()), ls, fr);
    end else begin
      feed_pixel(random_channel(), random_channel(), random_channel(),
                 dbtf_pkg::chan_t'($urandom()), ls, fr);
    end
  endtask

  task automatic feed_frame(input int cols, input int rows, input bit broken);
    logic ls;
    logic fr;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        ls = (c == 0);
        fr = mode_vertical ? (r == 0) : 1'($urandom());
        if (broken) begin
          if ($urandom_range(7) == 0) ls = ~ls;
          if ($urandom_range(3) == 0) fr = ~fr;
        end
        feed_random_pixel(ls, fr);
      end
    end
  endtask

  function automatic int unsigned pick_setting(int unsigned lo, int unsigned hi);
    case ($urandom_range(4))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  initial begin
    int          random_start;
    int          cols;
    idle_phase_t phase;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(IDLE_NONE);

    // Vertical trails: luma exactly at and just under the threshold, then a decaying row.
    program_settings(16'd65535, 16'h8000, 17'd65536, 1'b1);
    feed_pixel(dbtf_pkg::FULL_SCALE, dbtf_pkg::FULL_SCALE, dbtf_pkg::FULL_SCALE, '0,
               1'b1, 1'b1);
    feed_pixel(16'h8000, 16'h8000, 16'h8000, 16'hA5A5, 1'b0, 1'b1);
    feed_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h5A5A, 1'b0, 1'b1);
    feed_pixel('0, '0, '0, dbtf_pkg::FULL_SCALE, 1'b0, 1'b1);
    for (int c = 0; c < 4; c++) begin
      feed_pixel('0, '0, '0, dbtf_pkg::chan_t'($urandom()), c == 0, 1'b0);
    end
    drain();

    // Horizontal: a zero decay factor drops the previous trail, every pixel seeds, and a gain above unity saturates.
    program_settings('0, '0, 17'h1FFFF, 1'b0);
    feed_pixel(16'h4000, 16'h9000, 16'h1234, 16'h0001, 1'b1, 1'b0);
    feed_pixel('0, '0, '0, 16'h8000, 1'b0, 1'b1);
    feed_pixel(16'h8001, 16'h0001, dbtf_pkg::FULL_SCALE, 16'h7FFF, 1'b0, 1'b0);
    feed_pixel(16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 1'b1, 1'b1);
    drain();

    // Horizontal: only full white seeds, the trail halves per pixel, a line start clears it.
    program_settings(16'h8000, 16'hFFFF, 17'd65535, 1'b0);
    feed_pixel(dbtf_pkg::FULL_SCALE, dbtf_pkg::FULL_SCALE, dbtf_pkg::FULL_SCALE,
               dbtf_pkg::FULL_SCALE, 1'b1, 1'b0);
    feed_pixel(dbtf_pkg::FULL_SCALE, dbtf_pkg::FULL_SCALE, 16'hFFFE, '0, 1'b0, 1'b0);
    for (int c = 0; c < 3; c++) begin
      feed_pixel('0, '0, '0, dbtf_pkg::chan_t'($urandom()), 1'b0, 1'b0);
    end
    feed_pixel(16'h0100, 16'h0200, 16'h0300, 16'h1111, 1'b1, 1'b0);
    drain();

    random_start = pixels_fed;
    set_idling(IDLE_NONE);
    // Hold the output back for a long stretch while whole lines are still being offered.
    hold_requests++;
    feed_frame(16, 2, 1'b0);
    while (pixels_fed - random_start < RANDOM_PIXELS) begin
      if ($urandom_range(2) == 0) begin
        drain();
        program_settings(16'(pick_setting(0, 65535)), 16'(pick_setting(0, 65535)),
                         17'(pick_setting(0, 131071)), 1'($urandom()));
      end
      // The idling pattern moves on every quarter of the random part.
      phase = idle_phase_t'(((pixels_fed - random_start) * 4) / RANDOM_PIXELS);
      set_idling(phase);
      cols = ($urandom_range(7) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
      feed_frame(cols, $urandom_range(5, 1), $urandom_range(9) == 0);
    end
    drain();

    $display("Fed %0d pixels and checked %0d output words over %0d register settings,",
             pixels_fed, checked_count, settings_used);
    $display("in both trail directions, with threshold edges, gain saturation and stalls.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
